@@ rtl/mpcs_pkg.sv @@
package mpcs_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 16;

  localparam logic [2:0] FCFS = 3'd0;
  localparam logic [2:0] RR   = 3'd1;
  localparam logic [2:0] SPN  = 3'd2;
  localparam logic [2:0] SRT  = 3'd3;
  localparam logic [2:0] HRRN = 3'd4;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [0:0] CFG_POLICY  = 1'b0;
  localparam logic [0:0] CFG_QUANTUM = 1'b1;

  // Control that travels down the row of queue cells.
  typedef struct packed {
    logic push;     // append the pushed slot at the fill count
    logic remove;   // close the gap at the removal position
  } mpcs_qctl_t;

endpackage

@@ rtl/mpcs_cell.sv @@
module mpcs_cell #(
  parameter int SLOT_W = 4,
  parameter int POS_W  = 5,
  parameter int MY_POS = 0
) (
  input  logic                clk,
  input  mpcs_pkg::mpcs_qctl_t ctl,
  input  logic [POS_W-1:0]    tail,
  input  logic [POS_W-1:0]    rm_pos,
  input  logic [SLOT_W-1:0]   push_slot,
  input  logic [SLOT_W-1:0]   next_slot,
  output logic [SLOT_W-1:0]   slot
);
  import mpcs_pkg::*;

  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [POS_W-1:0]  me;
  logic [POS_W-1:0]  eff_tail;

  assign me = POS_W'(MY_POS);
  assign slot = slot_r;

  // The queue stays compacted: removal shifts later cells down by one, then
  // a push lands at the (possibly shortened) tail.
  always_comb begin
    slot_nxt = slot_r;
    eff_tail = tail;
    if (ctl.remove) begin
      eff_tail = tail - POS_W'(1);
      if (me >= rm_pos) begin
        slot_nxt = next_slot;
      end
    end
    if (ctl.push && me == eff_tail) begin
      slot_nxt = push_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end
endmodule

@@ rtl/multi_policy_cpu_scheduler.sv @@
// Multi-policy tick-driven process scheduler.
// Requests arrive on start/in_* and are taken when start is high and busy low.
// An arrival request (in_operation 0) places a process into slot in_process_index
// with in_service_time ticks of need, stamped with the current time, unless the
// slot is already ready or the need is zero; it produces no result and keeps busy
// high for one cycle. A tick request (in_operation 1) runs one time unit of the
// process picked by the selected policy, if any, and produces exactly one result,
// shown on the out_* ports for one cycle with out_valid high. The receiver cannot
// stall, so results are never held back. The ready queue is a row of cells, each
// holding one queue entry in arrival order. When the running process simply
// carries on, the request passes through the FIND, RUN and UPD states. Otherwise
// a pick walks the row one entry per cycle with one comparator in the SCAN state
// before RUN and UPD. Busy falls in the cycle that shows the result. Queue
// updates shift every cell of the row in parallel. The user must see that policy
// and quantum are written on cfg_* while the block is idle; the block does not enforce this.
// Reset (synchronous, rst_n low) clears time, ready flags, the queue count and
// the running process; per-slot tables are undefined until written.
module multi_policy_cpu_scheduler #(
  parameter int MAX_PROCESSES = mpcs_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_WIDTH    = mpcs_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [3:0]  in_process_index,
  input  logic [15:0] in_service_time,
  output logic        out_valid,
  output logic        out_busy_res,
  output logic [3:0]  out_running_index,
  output logic        out_finished,
  output logic [15:0] out_finish_time,
  output logic [15:0] out_turnaround,
  output logic [15:0] out_wait_time,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import mpcs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam int POS_W  = $clog2(MAX_PROCESSES + 1);
  localparam int TW     = TIME_WIDTH;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_ARR  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] mode_r;
  logic [7:0] quant_r;
  logic [TW-1:0] now_r;
  logic [MAX_PROCESSES-1:0] rdy_r;
  logic [POS_W-1:0] tail_r;
  logic [SLOT_W-1:0] run_slot_r;
  logic run_valid_r;
  logic [7:0] slice_r;

  logic [TW-1:0] rem_mem [MAX_PROCESSES];
  logic [TW-1:0] svc_mem [MAX_PROCESSES];
  logic [TW-1:0] arr_mem [MAX_PROCESSES];

  logic [SLOT_W-1:0] aidx_r;
  logic aidx_ok_r;
  logic [TW-1:0] asvc_r;
  logic [POS_W-1:0] pos_r, best_r, scan_r;
  logic [2:0] tmode_r;

  mpcs_qctl_t qctl;
  logic [POS_W-1:0] rm_pos;
  logic [SLOT_W-1:0] push_slot;
  logic [SLOT_W-1:0] qslot [MAX_PROCESSES+1];

  assign qslot[MAX_PROCESSES] = '0;

  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_row
    mpcs_cell #(.SLOT_W(SLOT_W), .POS_W(POS_W), .MY_POS(g)) u_cell (
      .clk(clk), .ctl(qctl), .tail(tail_r), .rm_pos(rm_pos),
      .push_slot(push_slot), .next_slot(qslot[g+1]), .slot(qslot[g])
    );
  end

  assign busy = (state_r != S_IDLE);

  // Slot at scan position, at best position and at the chosen position.
  logic [SLOT_W-1:0] a_slot, b_slot, sel_slot;
  assign a_slot   = qslot[scan_r[SLOT_W-1:0]];
  assign b_slot   = qslot[best_r[SLOT_W-1:0]];
  assign sel_slot = qslot[pos_r[SLOT_W-1:0]];

  // HRRN cross products: (wait+service) needs TW+1 bits.
  logic [TW:0] na, nb;
  logic [2*TW:0] pa, pb;
  logic better;
  assign na = {1'b0, now_r - arr_mem[a_slot]} + {1'b0, svc_mem[a_slot]};
  assign nb = {1'b0, now_r - arr_mem[b_slot]} + {1'b0, svc_mem[b_slot]};
  assign pa = na * svc_mem[b_slot];
  assign pb = nb * svc_mem[a_slot];
  always_comb begin
    case (tmode_r)
      SPN:     better = svc_mem[a_slot] < svc_mem[b_slot];
      SRT:     better = rem_mem[a_slot] < rem_mem[b_slot];
      HRRN:    better = pa > pb;
      default: better = 1'b0;
    endcase
  end

  // Found flag for the running process (one equality per cell).
  logic found;
  logic [POS_W-1:0] found_pos;
  always_comb begin
    found = 1'b0;
    found_pos = '0;
    for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
      if (POS_W'(i) < tail_r && qslot[i] == run_slot_r) begin
        found = 1'b1;
        found_pos = POS_W'(i);
      end
    end
  end

  // Completion figures use the clock after this tick.
  logic [TW-1:0] rem_dec, now_inc, ta, wt;
  logic [7:0] q_eff;
  logic run_fin;
  assign now_inc = (now_r < TMAX) ? now_r + TW'(1) : now_r;
  assign rem_dec = (rem_mem[sel_slot] != '0) ? rem_mem[sel_slot] - TW'(1) : '0;
  assign ta = now_inc - arr_mem[sel_slot];
  assign wt = (ta > svc_mem[sel_slot]) ? ta - svc_mem[sel_slot] : '0;
  assign q_eff = (quant_r == 8'd0) ? 8'd1 : quant_r;
  assign run_fin = (tail_r != '0) && (rem_dec == '0);

  logic [TW-1:0] svc_sat;
  always_comb begin
    if (TW >= 16) svc_sat = TW'(in_service_time);
    else if ((in_service_time >> TW) != 16'd0) svc_sat = TMAX;
    else svc_sat = TW'(in_service_time);
  end

  logic rr_expire;
  assign rr_expire = (tmode_r == RR) && (slice_r + 8'd1 >= q_eff);

  always_comb begin
    state_nxt = state_r;
    qctl = '0;
    rm_pos = pos_r;
    push_slot = aidx_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = (in_operation == OP_TICK) ? S_FIND : S_ARR;
      S_ARR:  begin
        state_nxt = S_IDLE;
        qctl.push = aidx_ok_r && !rdy_r[aidx_r] && asvc_r != '0 &&
                    tail_r < POS_W'(MAX_PROCESSES);
      end
      S_FIND: state_nxt = (tmode_r != SRT && run_valid_r && found) ? S_RUN : S_SCAN;
      S_SCAN: if (scan_r >= tail_r) state_nxt = S_RUN;
      S_RUN:  state_nxt = S_UPD;
      S_UPD:  begin
        state_nxt = S_IDLE;
        push_slot = sel_slot;
        if (out_finished) begin
          qctl.remove = 1'b1;
        end else if (rr_expire && out_busy_res) begin
          qctl.remove = 1'b1;
          qctl.push = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= FCFS;
      quant_r <= 8'd1;
      now_r <= '0;
      rdy_r <= '0;
      tail_r <= '0;
      run_slot_r <= '0;
      run_valid_r <= 1'b0;
      slice_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_UPD);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:  mode_r <= cfg_wdata[2:0];
          CFG_QUANTUM: quant_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (qctl.push && !qctl.remove) tail_r <= tail_r + POS_W'(1);
      if (qctl.remove && !qctl.push) tail_r <= tail_r - POS_W'(1);
      unique case (state_r)
        S_IDLE: begin
          aidx_r <= SLOT_W'(in_process_index);
          aidx_ok_r <= (32'(in_process_index) < MAX_PROCESSES);
          asvc_r <= svc_sat;
          tmode_r <= (mode_r > HRRN) ? FCFS : mode_r;
          best_r <= '0;
          scan_r <= POS_W'(1);
        end
        S_ARR: begin
          if (qctl.push) rdy_r[aidx_r] <= 1'b1;
        end
        S_FIND: begin
          if (tmode_r != SRT && run_valid_r) begin
            if (found) pos_r <= found_pos;
            else run_valid_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_r < tail_r) begin
            if (better) best_r <= scan_r;
            scan_r <= scan_r + POS_W'(1);
          end else begin
            pos_r <= best_r;
          end
        end
        S_RUN: begin
          now_r <= now_inc;
          out_finished <= run_fin;
          out_finish_time <= run_fin ? 16'(now_inc) : 16'd0;
          out_turnaround <= run_fin ? 16'(ta) : 16'd0;
          out_wait_time <= run_fin ? 16'(wt) : 16'd0;
          if (tail_r == '0) begin
            out_busy_res <= 1'b0;
            out_running_index <= '0;
            run_valid_r <= 1'b0;
            slice_r <= '0;
          end else begin
            out_busy_res <= 1'b1;
            out_running_index <= 4'(sel_slot);
            run_slot_r <= sel_slot;
            run_valid_r <= 1'b1;
            if (!run_valid_r || run_slot_r != sel_slot) slice_r <= '0;
          end
        end
        S_UPD: begin
          if (out_busy_res) begin
            if (out_finished) begin
              rdy_r[sel_slot] <= 1'b0;
              run_valid_r <= 1'b0;
              slice_r <= '0;
            end else if (tmode_r == RR) begin
              if (rr_expire) begin
                run_valid_r <= 1'b0;
                slice_r <= '0;
              end else begin
                slice_r <= slice_r + 8'd1;
              end
            end else begin
              slice_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ARR && qctl.push) begin
      rem_mem[aidx_r] <= asvc_r;
      svc_mem[aidx_r] <= asvc_r;
      arr_mem[aidx_r] <= now_r;
    end else if (state_r == S_RUN && tail_r != '0) begin
      rem_mem[sel_slot] <= rem_dec;
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= POS_W'(MAX_PROCESSES)) else $error("queue overfull");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(rdy_r) == 32'(tail_r)) else $error("ready count mismatch");
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_UPD) else $error("stray result");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> out_busy_res) else $error("finish without run");
endmodule

@@ tb/multi_policy_cpu_scheduler_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the multi-policy process scheduler.
// Requests (arrivals and ticks) are driven on the falling edge and sampled on the
// rising edge. A scoreboard object keeps its own copy of the scheduler state.
// It predicts the result of every accepted tick request and compares each
// strobed result against the oldest prediction.
module multi_policy_cpu_scheduler_tb;
  import mpcs_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [15:0] TMAX = 16'hFFFF;
  // Policy codes above HRRN, which the block treats as FCFS.
  localparam logic [2:0] POLICY_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] POLICY_UNKNOWN_HI = 3'd7;

  typedef struct {
    logic        busy_res;
    logic [3:0]  running_index;
    logic        finished;
    logic [15:0] fin_time;
    logic [15:0] turnaround;
    logic [15:0] idle_wait;
  } tick_result_t;

  // Shadow copy of the scheduler that predicts each tick result.
  class sched_scoreboard;
    logic [2:0]  policy;
    logic [7:0]  quantum;
    logic [15:0] now;
    logic [15:0] remaining [NSLOT];
    logic [15:0] need [NSLOT];
    logic [15:0] stamp [NSLOT];
    bit          ready [NSLOT];
    logic [3:0]  order [NSLOT];
    int          count;
    logic [3:0]  run_slot;
    bit          run_valid;
    int          slice;
    tick_result_t pending [$];
    int          errors;
    int          checked;
    int          completions;

    function void clear();
      policy = FCFS;
      quantum = 8'd1;
      now = '0;
      count = 0;
      run_slot = '0;
      run_valid = 0;
      slice = 0;
      foreach (ready[i]) ready[i] = 0;
      pending.delete();
    endfunction

    function void write_reg(logic [0:0] idx, logic [7:0] data);
      if (idx == CFG_POLICY) policy = data[2:0];
      else quantum = data;
    endfunction

    function void drop_entry(int pos);
      for (int i = pos; i + 1 < count; i++) order[i] = order[i+1];
      count--;
    endfunction

    function void append_entry(logic [3:0] slot);
      if (count < NSLOT) begin
        order[count] = slot;
        count++;
      end
    endfunction

    // Queue position that runs this tick, or -1 when nothing is ready.
    function int pick(logic [2:0] mode);
      int best;
      logic [3:0] a, b;
      longint unsigned na, nb;
      best = 0;
      if (mode != SRT && run_valid) begin
        for (int i = 0; i < count; i++)
          if (order[i] == run_slot) return i;
        run_valid = 0;
      end
      if (count == 0) return -1;
      for (int i = 1; i < count; i++) begin
        a = order[i];
        b = order[best];
        if (mode == SPN) begin
          if (need[a] < need[b]) best = i;
        end else if (mode == SRT) begin
          if (remaining[a] < remaining[b]) best = i;
        end else if (mode == HRRN) begin
          na = longint'(now - stamp[a]) + need[a];
          nb = longint'(now - stamp[b]) + need[b];
          if (na * need[b] > nb * need[a]) best = i;
        end
      end
      return best;
    endfunction

    function void note_request(logic op, logic [3:0] idx, logic [15:0] svc);
      logic [2:0] mode;
      int q, pos;
      logic [3:0] slot;
      tick_result_t r;
      logic [15:0] ta;
      if (op == OP_ARRIVE) begin
        if (svc == 0 || ready[idx]) return;
        remaining[idx] = svc;
        need[idx] = svc;
        stamp[idx] = now;
        ready[idx] = 1;
        append_entry(idx);
        return;
      end
      mode = (policy > HRRN) ? FCFS : policy;
      q = (quantum == 0) ? 1 : quantum;
      r = '{default: '0};
      pos = pick(mode);
      if (now < TMAX) now++;
      if (pos < 0) begin
        run_valid = 0;
        slice = 0;
        pending.insert(pending.size(), r);
        return;
      end
      slot = order[pos];
      if (!run_valid || run_slot != slot) slice = 0;
      run_slot = slot;
      run_valid = 1;
      r.busy_res = 1;
      r.running_index = slot;
      if (remaining[slot] > 0) remaining[slot]--;
      if (remaining[slot] == 0) begin
        ta = now - stamp[slot];
        r.finished = 1;
        r.fin_time = now;
        r.turnaround = ta;
        r.idle_wait = (ta > need[slot]) ? ta - need[slot] : '0;
        ready[slot] = 0;
        drop_entry(pos);
        run_valid = 0;
        slice = 0;
        completions++;
      end else if (mode == RR) begin
        slice++;
        if (slice >= q) begin
          drop_entry(pos);
          append_entry(slot);
          run_valid = 0;
          slice = 0;
        end
      end else begin
        slice = 0;
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result busy=%0d idx=%0d", $time, got.busy_res,
                 got.running_index);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.busy_res !== exp.busy_res || got.running_index !== exp.running_index ||
          got.finished !== exp.finished || got.fin_time !== exp.fin_time ||
          got.turnaround !== exp.turnaround || got.idle_wait !== exp.idle_wait) begin
        $display("%0t: mismatch exp busy=%0d idx=%0d fin=%0d ft=%0d ta=%0d wt=%0d",
                 $time, exp.busy_res, exp.running_index, exp.finished,
                 exp.fin_time, exp.turnaround, exp.idle_wait);
        $display("%0t:          act busy=%0d idx=%0d fin=%0d ft=%0d ta=%0d wt=%0d",
                 $time, got.busy_res, got.running_index, got.finished,
                 got.fin_time, got.turnaround, got.idle_wait);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [3:0]  in_process_index;
  logic [15:0] in_service_time;
  logic        out_valid;
  logic        out_busy_res;
  logic [3:0]  out_running_index;
  logic        out_finished;
  logic [15:0] out_finish_time;
  logic [15:0] out_turnaround;
  logic [15:0] out_wait_time;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  sched_scoreboard sb;
  int requests_sent;

  multi_policy_cpu_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_process_index(in_process_index),
    .in_service_time(in_service_time), .out_valid(out_valid),
    .out_busy_res(out_busy_res), .out_running_index(out_running_index),
    .out_finished(out_finished), .out_finish_time(out_finish_time),
    .out_turnaround(out_turnaround), .out_wait_time(out_wait_time),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Monitor: every rising edge, first check a strobed result, then record an
  // accepted request or register write in the scoreboard. Inputs only change on
  // the falling edge, so the values read here are stable.
  always @(posedge clk) begin
    tick_result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.busy_res = out_busy_res;
        got.running_index = out_running_index;
        got.finished = out_finished;
        got.fin_time = out_finish_time;
        got.turnaround = out_turnaround;
        got.idle_wait = out_wait_time;
        sb.check_result(got);
      end
      if (start && !busy) sb.note_request(in_operation, in_process_index, in_service_time);
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  // Sends one request. Called and returning on a falling edge; start is left
  // high afterwards so back-to-back requests need only one assignment per edge.
  task automatic send_request(logic op, logic [3:0] idx, logic [15:0] svc, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_process_index <= idx;
    in_service_time <= svc;
    do @(posedge clk); while (busy);
    requests_sent++;
    @(negedge clk);
  endtask

  // Holds off until every predicted result has arrived, then lets the block
  // finish any arrival it may still be storing, since arrivals give no result.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly short jobs so that processes complete often, now and then a long one.
  task automatic random_request(int gap_pct);
    logic [15:0] svc;
    if ($urandom_range(99) < 45) begin
      case ($urandom_range(19))
        0:       svc = '0;
        1:       svc = 16'($urandom_range(300, 30));
        default: svc = 16'($urandom_range(12, 1));
      endcase
      send_request(OP_ARRIVE, 4'($urandom_range(15)), svc, gap_pct);
    end else begin
      send_request(OP_TICK, 4'($urandom), 16'($urandom), gap_pct);
    end
  endtask

  initial begin
    int modes [10];
    int quanta [10];
    int gaps [4];
    modes = '{FCFS, RR, RR, RR, SPN, SRT, HRRN, POLICY_UNKNOWN_LO, POLICY_UNKNOWN_HI, RR};
    quanta = '{1, 1, 255, 0, 3, 2, 1, 1, 1, 5};
    gaps = '{0, 45, 34, 0};
    sb = new();
    sb.errors = 0;
    sb.checked = 0;
    sb.completions = 0;
    requests_sent = 0;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_ARRIVE;
    in_process_index = '0;
    in_service_time = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_wdata = '0;
    sb.clear();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset policy (FCFS): an idle tick, a zero-service
    // arrival, an arrival into an occupied slot, and the extreme slot numbers.
    send_request(OP_TICK, 4'hF, 16'hFFFF, 0);
    send_request(OP_ARRIVE, 4'd0, 16'd0, 0);
    send_request(OP_ARRIVE, 4'd0, 16'd3, 0);
    send_request(OP_ARRIVE, 4'd0, 16'd5, 0);
    send_request(OP_ARRIVE, 4'd15, 16'd1, 0);
    send_request(OP_ARRIVE, 4'd7, 16'd2, 0);
    repeat (7) send_request(OP_TICK, 4'd0, 16'd0, 0);
    // A process left running when the policy changes keeps going under HRRN.
    send_request(OP_ARRIVE, 4'd4, 16'd4, 0);
    send_request(OP_ARRIVE, 4'd5, 16'd1, 0);
    send_request(OP_TICK, 4'd0, 16'd0, 0);
    wait_idle();
    write_reg(CFG_POLICY, {5'b11111, HRRN});
    repeat (5) send_request(OP_TICK, 4'd0, 16'd0, 0);

    // Random phases, each under its own policy, quantum and idling level.
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      write_reg(CFG_POLICY, {5'($urandom), 3'(modes[p])});
      write_reg(CFG_QUANTUM, 8'(quanta[p]));
      for (int n = 0; n < 113; n++) random_request(gaps[p % 4]);
    end

    // Final phase: a process with the largest service time joins under FCFS
    // and runs for a while behind whatever is still queued.
    wait_idle();
    write_reg(CFG_POLICY, {5'b00000, FCFS});
    send_request(OP_ARRIVE, 4'd15, 16'hFFFF, 0);
    repeat (20) send_request(OP_TICK, 4'd0, 16'd0, 0);

    wait_idle();
    if (sb.pending.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d requests over all five policies, unknown codes and quantum extremes;",
             requests_sent);
    $display("checked %0d tick results, %0d with a completion, %0d errors.",
             sb.checked, sb.completions, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
